>>> hw/rtl/scaq_pkg.sv
// -----------------------------------------------------------------------------
// scaq_pkg: shared types and constants for the scaled clock with alarm queue
// Opcodes, command kinds, status codes, sequencer states and the records that
// pass between the front queue, the execution back end and the result port.
// -----------------------------------------------------------------------------
package scaq_pkg;

   // Default number of alarm slots
   localparam int ALARM_SLOTS_DEF = 16;
   // Most alarms one tick may fire
   localparam int MAX_FIRE = 16;
   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Field widths
   localparam int OPCODE_W = 3;
   localparam int DELTA_W  = 32;
   localparam int ID_W     = 8;
   localparam int TIME_W   = 48;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = DELTA_W + SCALE_W;
   localparam int SHIFT_Q  = 8;

   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(256);

   // Input opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK      = 3'd0,
      OP_ALARM_ABS = 3'd1,
      OP_ALARM_REL = 3'd2,
      OP_SET_TIME  = 3'd3,
      OP_RESET     = 3'd4,
      OP_PAUSE     = 3'd5,
      OP_UNPAUSE   = 3'd6
   } op_type;

   // Command kinds handed to the back end
   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_ALARM_ABS,
      CMD_ALARM_REL,
      CMD_SET_TIME,
      CMD_CLEAR,
      CMD_PAUSE,
      CMD_RESUME,
      CMD_NOP
   } cmd_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_TICK_MUL,
      BK_TICK_ADD,
      BK_FIRE_CHK,
      BK_FIRE_CMP,
      BK_FIRE_END,
      BK_INS_RD,
      BK_INS_CMP,
      BK_EMIT
   } back_state_type;

   // Classified command
   typedef struct packed {
      cmd_kind_type        kind;
      logic [DELTA_W-1:0]  delta_time;
      logic [ID_W-1:0]     alarm_id;
      logic [TIME_W-1:0]   time_value;
   } cmd_type;

   // One alarm table entry
   typedef struct packed {
      logic [TIME_W-1:0] fire_time;
      logic [ID_W-1:0]   id;
   } alarm_type;

   // One result item
   typedef struct packed {
      logic               alarm_fired;
      logic [ID_W-1:0]    fired_id;
      logic               last_result;
      status_type         status;
      logic [TIME_W-1:0]  elapsed_now;
      logic [DELTA_W-1:0] delta_applied;
   } rsp_type;

endpackage

>>> hw/rtl/scaq_front.sv
// -----------------------------------------------------------------------------
// scaq_front: request intake and command queue
// Accepts request transfers, decodes the opcode into a command kind and holds
// the commands in a short queue until the back end takes them.
// -----------------------------------------------------------------------------
module scaq_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [scaq_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [scaq_pkg::DELTA_W-1:0]    req_delta_time,
   input  logic [scaq_pkg::ID_W-1:0]       req_alarm_id,
   input  logic [scaq_pkg::TIME_W-1:0]     req_time_value,
   output logic                            cmd_valid,
   input  logic                            cmd_pop,
   output scaq_pkg::cmd_type               cmd
);

   scaq_pkg::cmd_type                      slot_ff [scaq_pkg::CMDQ_DEPTH];
   logic [scaq_pkg::CMDQ_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [scaq_pkg::CMDQ_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [scaq_pkg::CMDQ_CNT_W-1:0]        fill_ff, fill_in;
   logic                                   push_ok;
   logic                                   pop_ok;
   scaq_pkg::cmd_kind_type                 kind;
   scaq_pkg::cmd_type                      cmd_new;

   // Classify the opcode; the unused code becomes a no-op
   always_comb begin
      unique case (req_opcode)
         scaq_pkg::OP_TICK:      kind = scaq_pkg::CMD_TICK;
         scaq_pkg::OP_ALARM_ABS: kind = scaq_pkg::CMD_ALARM_ABS;
         scaq_pkg::OP_ALARM_REL: kind = scaq_pkg::CMD_ALARM_REL;
         scaq_pkg::OP_SET_TIME:  kind = scaq_pkg::CMD_SET_TIME;
         scaq_pkg::OP_RESET:     kind = scaq_pkg::CMD_CLEAR;
         scaq_pkg::OP_PAUSE:     kind = scaq_pkg::CMD_PAUSE;
         scaq_pkg::OP_UNPAUSE:   kind = scaq_pkg::CMD_RESUME;
         default:                kind = scaq_pkg::CMD_NOP;
      endcase
   end

   assign cmd_new.kind       = kind;
   assign cmd_new.delta_time = req_delta_time;
   assign cmd_new.alarm_id   = req_alarm_id;
   assign cmd_new.time_value = req_time_value;

   // Queue flags and pointer updates
   assign req_full  = (fill_ff == scaq_pkg::CMDQ_CNT_W'(scaq_pkg::CMDQ_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd       = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (push_ok && !pop_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Hold queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

>>> hw/rtl/scaq_back.sv
// -----------------------------------------------------------------------------
// scaq_back: clock state, alarm table and result register
// Executes one command at a time: scales and applies tick deltas, walks the
// due alarms in fire order, inserts new alarms in sorted order and loads one
// result per report into the output register.
// -----------------------------------------------------------------------------
module scaq_back #(
   parameter int ALARM_SLOTS = scaq_pkg::ALARM_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [scaq_pkg::SCALE_W-1:0]    csr_wr_data,
   input  logic                            cmd_valid,
   output logic                            cmd_pop,
   input  scaq_pkg::cmd_type               cmd,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output scaq_pkg::rsp_type               rsp
);

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int TW    = scaq_pkg::TIME_W;
   localparam int DW    = scaq_pkg::DELTA_W;

   // Physical slot of a logical position behind the head
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(ALARM_SLOTS)) begin
         s = s - SUM_W'(ALARM_SLOTS);
      end
      return s[IDX_W-1:0];
   endfunction

   scaq_pkg::back_state_type          state_ff, state_in;
   scaq_pkg::cmd_type                 cur_ff, cur_in;
   logic [scaq_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [TW-1:0]                     elapsed_ff, elapsed_in;
   logic [DW-1:0]                     delta_ff, delta_in;
   logic                              paused_ff, paused_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [IDX_W-1:0]                  head_ff, head_in;
   scaq_pkg::status_type              status_ff, status_in;
   logic [CNT_W-1:0]                  idx_ff, idx_in;
   logic [TW-1:0]                     target_ff, target_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [scaq_pkg::ID_W-1:0]         pend_id_ff, pend_id_in;
   logic [scaq_pkg::PROD_W-1:0]       prod_ff, prod_in;
   scaq_pkg::alarm_type               alarm_mem [ALARM_SLOTS];
   scaq_pkg::alarm_type               rd_ff;
   logic [IDX_W-1:0]                  rd_addr;
   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   scaq_pkg::alarm_type               wr_data;
   logic                              rsp_valid_ff, rsp_valid_in;
   scaq_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              rsp_load;
   logic                              slot_free;
   logic                              table_full;
   logic                              fire_more;
   logic                              due;
   logic                              later;
   logic [TW:0]                       rel_sum;
   logic [TW-scaq_pkg::SHIFT_Q-DW+DW-1:0] d_raw;
   logic                              d_sat;
   logic [DW-1:0]                     d_val;
   logic [TW:0]                       tick_sum;
   logic [CNT_W-1:0]                  prev_off;

   // Shared conditions
   assign slot_free  = !rsp_valid_ff || rsp_pop;
   assign table_full = (count_ff >= CNT_W'(ALARM_SLOTS));
   assign fire_more  = (idx_ff < count_ff) && (32'(idx_ff) < scaq_pkg::MAX_FIRE);
   assign due        = (rd_ff.fire_time <= elapsed_ff);
   assign later      = (rd_ff.fire_time > target_ff);
   assign rel_sum    = {1'b0, elapsed_ff} + {1'b0, cmd.time_value};
   assign d_raw      = prod_ff[scaq_pkg::PROD_W-1:scaq_pkg::SHIFT_Q];
   assign d_sat      = |d_raw[$bits(d_raw)-1:DW];
   assign d_val      = paused_ff ? '0 : (d_sat ? '1 : d_raw[DW-1:0]);
   assign tick_sum   = {1'b0, elapsed_ff} + (TW+1)'(d_val);
   assign prev_off   = (idx_ff > CNT_W'(1)) ? idx_ff - CNT_W'(2) : '0;
   assign cmd_pop    = (state_ff == scaq_pkg::BK_IDLE) && cmd_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scaq_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  scaq_pkg::CMD_TICK: state_in = scaq_pkg::BK_TICK_MUL;
                  scaq_pkg::CMD_ALARM_ABS,
                  scaq_pkg::CMD_ALARM_REL:
                     state_in = table_full ? scaq_pkg::BK_EMIT : scaq_pkg::BK_INS_RD;
                  default: state_in = scaq_pkg::BK_EMIT;
               endcase
            end
         end
         scaq_pkg::BK_TICK_MUL: state_in = scaq_pkg::BK_TICK_ADD;
         scaq_pkg::BK_TICK_ADD: state_in = scaq_pkg::BK_FIRE_CHK;
         scaq_pkg::BK_FIRE_CHK:
            state_in = fire_more ? scaq_pkg::BK_FIRE_CMP : scaq_pkg::BK_FIRE_END;
         scaq_pkg::BK_FIRE_CMP: begin
            priority if (!due) begin
               state_in = scaq_pkg::BK_FIRE_END;
            end else if (!pend_valid_ff || slot_free) begin
               state_in = scaq_pkg::BK_FIRE_CHK;
            end
         end
         scaq_pkg::BK_FIRE_END: begin
            if (slot_free) begin
               state_in = scaq_pkg::BK_IDLE;
            end
         end
         scaq_pkg::BK_INS_RD:
            state_in = (idx_ff == '0) ? scaq_pkg::BK_EMIT : scaq_pkg::BK_INS_CMP;
         scaq_pkg::BK_INS_CMP: begin
            priority if (!later) begin
               state_in = scaq_pkg::BK_EMIT;
            end else if (idx_ff == CNT_W'(1)) begin
               state_in = scaq_pkg::BK_INS_RD;
            end
         end
         scaq_pkg::BK_EMIT: begin
            if (slot_free) begin
               state_in = scaq_pkg::BK_IDLE;
            end
         end
         default: state_in = scaq_pkg::BK_IDLE;
      endcase
   end

   // Datapath, table access and result loads
   always_comb begin
      cur_in        = cur_ff;
      scale_in      = csr_wr_en ? csr_wr_data : scale_ff;
      elapsed_in    = elapsed_ff;
      delta_in      = delta_ff;
      paused_in     = paused_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      target_in     = target_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      prod_in       = prod_ff;
      rd_addr       = slot_at(head_ff, idx_ff);
      wr_en         = 1'b0;
      wr_addr       = slot_at(head_ff, idx_ff);
      wr_data       = rd_ff;
      rsp_load      = 1'b0;
      rsp_in.alarm_fired   = 1'b0;
      rsp_in.fired_id      = '0;
      rsp_in.last_result   = 1'b1;
      rsp_in.status        = status_ff;
      rsp_in.elapsed_now   = elapsed_ff;
      rsp_in.delta_applied = delta_ff;

      unique case (state_ff)
         // Take a command and apply the simple ones at once
         scaq_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cur_in    = cmd;
               status_in = scaq_pkg::STATUS_OK;
               unique case (cmd.kind)
                  scaq_pkg::CMD_ALARM_ABS,
                  scaq_pkg::CMD_ALARM_REL: begin
                     if (table_full) begin
                        status_in = scaq_pkg::STATUS_FULL;
                     end else begin
                        idx_in = count_ff;
                        if (cmd.kind == scaq_pkg::CMD_ALARM_REL) begin
                           target_in = rel_sum[TW] ? '1 : rel_sum[TW-1:0];
                           if (rel_sum[TW]) begin
                              status_in = scaq_pkg::STATUS_SAT;
                           end
                        end else begin
                           target_in = cmd.time_value;
                        end
                     end
                  end
                  scaq_pkg::CMD_SET_TIME: elapsed_in = cmd.time_value;
                  scaq_pkg::CMD_CLEAR: begin
                     elapsed_in = '0;
                     delta_in   = '0;
                     paused_in  = 1'b0;
                  end
                  scaq_pkg::CMD_PAUSE:  paused_in = 1'b1;
                  scaq_pkg::CMD_RESUME: paused_in = 1'b0;
                  default: ;
               endcase
            end
         end
         // Scale the delta
         scaq_pkg::BK_TICK_MUL: begin
            prod_in = scaq_pkg::PROD_W'(cur_ff.delta_time) *
                      scaq_pkg::PROD_W'(scale_ff);
         end
         // Apply the delta with saturation
         scaq_pkg::BK_TICK_ADD: begin
            delta_in      = d_val;
            elapsed_in    = tick_sum[TW] ? '1 : tick_sum[TW-1:0];
            status_in     = ((!paused_ff && d_sat) || tick_sum[TW]) ?
                            scaq_pkg::STATUS_SAT : scaq_pkg::STATUS_OK;
            idx_in        = '0;
            pend_valid_in = 1'b0;
         end
         scaq_pkg::BK_FIRE_CHK: ;
         // Advance over a due alarm; report the previous one as not last
         scaq_pkg::BK_FIRE_CMP: begin
            if (due && (!pend_valid_ff || slot_free)) begin
               if (pend_valid_ff) begin
                  rsp_load             = 1'b1;
                  rsp_in.alarm_fired   = 1'b1;
                  rsp_in.fired_id      = pend_id_ff;
                  rsp_in.last_result   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = rd_ff.id;
               idx_in        = idx_ff + 1'b1;
            end
         end
         // Report the final alarm, or no alarm, and drop fired entries
         scaq_pkg::BK_FIRE_END: begin
            if (slot_free) begin
               rsp_load           = 1'b1;
               rsp_in.alarm_fired = pend_valid_ff;
               rsp_in.fired_id    = pend_valid_ff ? pend_id_ff : '0;
               head_in            = slot_at(head_ff, idx_ff);
               count_in           = count_ff - idx_ff;
            end
         end
         // Read the neighbor below, or place the alarm at the front
         scaq_pkg::BK_INS_RD: begin
            rd_addr = slot_at(head_ff, idx_ff - CNT_W'(1));
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               wr_data  = '{fire_time: target_ff, id: cur_ff.alarm_id};
               count_in = count_ff + 1'b1;
            end
         end
         // Shift a later entry up, or place the alarm above it
         scaq_pkg::BK_INS_CMP: begin
            rd_addr = slot_at(head_ff, prev_off);
            wr_en   = 1'b1;
            if (later) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               wr_data  = '{fire_time: target_ff, id: cur_ff.alarm_id};
               count_in = count_ff + 1'b1;
            end
         end
         scaq_pkg::BK_EMIT: begin
            rsp_load = slot_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_pop);
   assign rsp_empty    = !rsp_valid_ff;
   assign rsp          = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scaq_pkg::BK_IDLE;
         scale_ff      <= scaq_pkg::SCALE_ONE;
         elapsed_ff    <= '0;
         delta_ff      <= '0;
         paused_ff     <= 1'b0;
         count_ff      <= '0;
         head_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         elapsed_ff    <= elapsed_in;
         delta_ff      <= delta_in;
         paused_ff     <= paused_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      status_ff  <= status_in;
      idx_ff     <= idx_in;
      target_ff  <= target_in;
      pend_id_ff <= pend_id_in;
      prod_ff    <= prod_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Alarm table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         alarm_mem[wr_addr] <= wr_data;
      end
      rd_ff <= alarm_mem[rd_addr];
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ALARM_SLOTS))
      else $error("alarm count beyond table size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_pop))
      else $error("result register overwritten before transfer");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scaq_pkg::BK_INS_RD || state_ff == scaq_pkg::BK_INS_CMP)
      |-> (count_ff < CNT_W'(ALARM_SLOTS)))
      else $error("insert started on a full table");

   a_fire_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scaq_pkg::BK_FIRE_CMP) |-> (idx_ff < count_ff))
      else $error("fire check beyond pending alarms");

endmodule

>>> hw/rtl/scaled_clock_with_alarm_queue_top.sv
// -----------------------------------------------------------------------------
// scaled_clock_with_alarm_queue_top: scaled clock with sorted alarm queue
// Elapsed-time counter driven by scaled ticks, with a table of pending alarms
// kept in fire-time order; a tick reports one result per fired alarm, or one if none fires.
//
//   Channel   Handshake          Payload
//   req_      push / full        opcode, delta_time, alarm_id, time_value
//   rsp_      pop / empty        alarm_fired, fired_id, last_result, status,
//                                elapsed_now, delta_applied
//   csr_      wr_en              wr_data = time_scale (Q8.8)
//
// Pause, unpause, reset, set, no-op and a dropped alarm go straight to the result;
// an alarm insert shifts each later entry up one slot before placing the alarm;
// a tick scales and adds its delta, then reports each due alarm and stops on an
// alarm not yet due. Two commands queue ahead of the sequencer.
// Reset clears the clock, the pause flag, the queue and the alarm count.
// A stalled result holds the sequencer only when it has the next one ready.
// -----------------------------------------------------------------------------
module scaled_clock_with_alarm_queue_top #(
   parameter int ALARM_SLOTS = scaq_pkg::ALARM_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [scaq_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [scaq_pkg::DELTA_W-1:0]    req_delta_time,
   input  logic [scaq_pkg::ID_W-1:0]       req_alarm_id,
   input  logic [scaq_pkg::TIME_W-1:0]     req_time_value,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_alarm_fired,
   output logic [scaq_pkg::ID_W-1:0]       rsp_fired_id,
   output logic                            rsp_last_result,
   output logic [1:0]                      rsp_status,
   output logic [scaq_pkg::TIME_W-1:0]     rsp_elapsed_now,
   output logic [scaq_pkg::DELTA_W-1:0]    rsp_delta_applied,
   input  logic                            csr_wr_en,
   input  logic [scaq_pkg::SCALE_W-1:0]    csr_wr_data
);

   logic                cmd_valid;
   logic                cmd_pop;
   scaq_pkg::cmd_type   cmd;
   scaq_pkg::rsp_type   rsp;

   // Intake and command queue
   scaq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_delta_time (req_delta_time),
      .req_alarm_id   (req_alarm_id),
      .req_time_value (req_time_value),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd)
   );

   // Execution and result register
   scaq_back #(
      .ALARM_SLOTS (ALARM_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp         (rsp)
   );

   // Unpack the result record
   assign rsp_alarm_fired   = rsp.alarm_fired;
   assign rsp_fired_id      = rsp.fired_id;
   assign rsp_last_result   = rsp.last_result;
   assign rsp_status        = rsp.status;
   assign rsp_elapsed_now   = rsp.elapsed_now;
   assign rsp_delta_applied = rsp.delta_applied;

endmodule
